// ----- rtl/mhsig_pkg.sv -----
// Shared types, codes and remainder helpers of the MinHash signature engine.
package mhsig_pkg;

  // Field widths of the input and result items.
  localparam int CMD_W      = 2;
  localparam int SLOT_FW    = 4;
  localparam int COEF_W     = 16;
  localparam int HASH_W     = 64;
  localparam int VAL_W      = 8;
  localparam int ACT_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Results per emit never exceed this count.
  localparam int RESULT_LIMIT = 16;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ABSORB = 2'd2;
  localparam logic [CMD_W-1:0] CMD_EMIT   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd1;

  typedef logic [VAL_W-1:0]   val_t;
  typedef logic [ACT_W-1:0]   cnt_t;
  typedef logic [SLOT_FW-1:0] sidx_t;

  localparam cnt_t ACTIVE_RST  = 5'd16;
  localparam val_t MODULUS_RST = 8'd37;
  localparam val_t MODULUS_MIN = 8'd2;

  // Element hash reduction: HASH_DIGIT bits per cycle.
  localparam int HASH_DIGIT = 4;
  localparam int HASH_ITERS = HASH_W / HASH_DIGIT;
  localparam int HCNT_W     = $clog2(HASH_ITERS);
  typedef logic [HCNT_W-1:0] hcnt_t;
  localparam hcnt_t HCNT_LAST = hcnt_t'(HASH_ITERS - 1);

  // a*x+b stays below 2^24 since x is below the modulus.
  localparam int PROD_W     = 24;
  localparam int REM_STAGES = 4;
  localparam int REM_STEPS  = PROD_W / REM_STAGES;
  typedef logic [PROD_W-1:0] prod_t;

  // Payload of one slot in the remainder pipeline.
  typedef struct packed {
    val_t  rem;
    prod_t bits;
    val_t  old;
    sidx_t slot;
  } stage_t;

  // One restoring step: shift in one bit, subtract the modulus once if needed.
  function automatic val_t rem_step(val_t r, logic b, val_t p);
    logic [VAL_W:0] t;
    t = {r, b};
    if (t >= {1'b0, p}) begin
      rem_step = val_t'(t - {1'b0, p});
    end else begin
      rem_step = val_t'(t);
    end
  endfunction

  function automatic val_t rem_hash_digit(val_t r, logic [HASH_DIGIT-1:0] d, val_t p);
    val_t acc;
    acc = r;
    for (int k = HASH_DIGIT - 1; k >= 0; k--) begin
      acc = rem_step(acc, d[k], p);
    end
    rem_hash_digit = acc;
  endfunction

  function automatic val_t rem_chunk(val_t r, logic [REM_STEPS-1:0] d, val_t p);
    val_t acc;
    acc = r;
    for (int k = REM_STEPS - 1; k >= 0; k--) begin
      acc = rem_step(acc, d[k], p);
    end
    rem_chunk = acc;
  endfunction

endpackage

// ----- rtl/minhash_signature_engine.sv -----
// MinHash signature engine: coefficient and signature memories with a modular update pipeline.
//
//   Channel | Direction | Handshake       | Payload
//   in_     | input     | valid / stall   | cmd, slot, mult_coef, add_coef, element_hash
//   out_    | output    | valid / stall   | sig_value, sig_slot, last
//   cfg_    | input     | valid / ready   | index, data (active_hashes, modulus)
//
// A load or clear request acts as it is taken and leaves the sequencer idle. An absorb request
// first reduces the 64-bit hash four bits a cycle, then one slot a cycle is read from the
// memories and streams through a multiply stage and four remainder stages. An emit request
// reads each slot in ST_EMIT_RD and moves it into the output register in ST_EMIT_LD, where it
// waits while the result side stalls.
// Reset clears the signature through per-slot valid bits at once; no clearing pass is run.
// A stalled result holds in the output register while the next request is already taken.
module minhash_signature_engine #(
  parameter int MAX_HASHES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Request channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mhsig_pkg::CMD_W-1:0]          in_cmd,
  input  logic [mhsig_pkg::SLOT_FW-1:0]        in_slot,
  input  logic [mhsig_pkg::COEF_W-1:0]         in_mult_coef,
  input  logic [mhsig_pkg::COEF_W-1:0]         in_add_coef,
  input  logic [mhsig_pkg::HASH_W-1:0]         in_element_hash,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mhsig_pkg::VAL_W-1:0]          out_sig_value,
  output logic [mhsig_pkg::SLOT_FW-1:0]        out_sig_slot,
  output logic                                 out_last,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mhsig_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mhsig_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SLOT_W = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam int LIMIT_I = (MAX_HASHES < mhsig_pkg::RESULT_LIMIT) ?
                           MAX_HASHES : mhsig_pkg::RESULT_LIMIT;
  localparam mhsig_pkg::cnt_t LIMIT = mhsig_pkg::cnt_t'(LIMIT_I);
  localparam int LAST_ST = mhsig_pkg::REM_STAGES;
  localparam int COEF_MW = 2 * mhsig_pkg::COEF_W;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MOD     = 3'd1;
  localparam logic [2:0] ST_ISSUE   = 3'd2;
  localparam logic [2:0] ST_DRAIN   = 3'd3;
  localparam logic [2:0] ST_EMIT_RD = 3'd4;
  localparam logic [2:0] ST_EMIT_LD = 3'd5;

  logic [2:0]               state_r, state_nxt;
  mhsig_pkg::sidx_t         idx_r, idx_nxt;
  mhsig_pkg::hcnt_t         hcnt_r;
  logic [mhsig_pkg::HASH_W-1:0] hash_r;
  mhsig_pkg::val_t          x_r;

  mhsig_pkg::cnt_t          active_r;
  mhsig_pkg::val_t          modulus_r;
  mhsig_pkg::val_t          clear_val_r;
  logic [MAX_HASHES-1:0]    sig_vld_r;

  // Coefficient pairs {a, b} and signature minimums.
  logic [COEF_MW-1:0]       coef_mem [MAX_HASHES];
  mhsig_pkg::val_t          sig_mem  [MAX_HASHES];

  logic                     rd_en;
  logic [SLOT_W-1:0]        rd_addr;
  logic [COEF_MW-1:0]       coef_rd_r;
  mhsig_pkg::val_t          sig_rd_r;
  logic                     sigv_rd_r;
  logic                     rd_vld_r;
  mhsig_pkg::sidx_t         rd_slot_r;

  logic [LAST_ST:0]         st_vld_r;
  mhsig_pkg::stage_t        st_r [LAST_ST+1];

  logic                     out_valid_r;
  mhsig_pkg::val_t          out_value_r;
  mhsig_pkg::sidx_t         out_slot_r;
  logic                     out_last_r;

  logic                     in_accept;
  logic                     cfg_accept;
  logic                     out_free;
  logic                     out_load;
  logic                     pipe_busy;
  logic                     idx_last;
  logic                     wb_en;
  logic [SLOT_W-1:0]        wb_addr;
  mhsig_pkg::val_t          eff_mod;
  mhsig_pkg::cnt_t          cnt_n;
  mhsig_pkg::val_t          slot_value;

  // Requests are taken only while the sequencer is idle; configuration is always taken.
  assign in_stall   = (state_r != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;

  // A modulus below two acts as two; the slot count saturates at the smaller of the table size and RESULT_LIMIT.
  assign eff_mod  = (modulus_r < mhsig_pkg::MODULUS_MIN) ? mhsig_pkg::MODULUS_MIN : modulus_r;
  assign cnt_n    = (active_r > LIMIT) ? LIMIT : active_r;
  assign idx_last = ((mhsig_pkg::cnt_t'(idx_r) + mhsig_pkg::cnt_t'(1)) == cnt_n);

  assign out_free  = !out_valid_r || !out_stall;
  assign pipe_busy = rd_vld_r || (|st_vld_r);

  // A slot never updated since the last clear reads as the modulus captured at that clear.
  assign slot_value = sigv_rd_r ? sig_rd_r : clear_val_r;

  // Sequencer: absorb reduces the hash, issues one slot a cycle and waits for the pipeline
  // to drain; emit reads a slot and moves it into the output register once that is free.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    rd_en     = 1'b0;
    rd_addr   = SLOT_W'(idx_r);
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_cmd)
            mhsig_pkg::CMD_ABSORB: begin
              if (cnt_n != '0) begin
                state_nxt = ST_MOD;
              end
            end
            mhsig_pkg::CMD_EMIT: begin
              if (cnt_n != '0) begin
                state_nxt = ST_EMIT_RD;
                idx_nxt   = '0;
              end
            end
            mhsig_pkg::CMD_LOAD, mhsig_pkg::CMD_CLEAR: begin
            end
          endcase
        end
      end
      ST_MOD: begin
        if (hcnt_r == mhsig_pkg::HCNT_LAST) begin
          state_nxt = ST_ISSUE;
          idx_nxt   = '0;
        end
      end
      ST_ISSUE: begin
        rd_en = 1'b1;
        if (idx_last) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + mhsig_pkg::sidx_t'(1);
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (idx_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + mhsig_pkg::sidx_t'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= mhsig_pkg::ACTIVE_RST;
      modulus_r <= mhsig_pkg::MODULUS_RST;
    end else if (cfg_accept) begin
      unique case (cfg_index)
        mhsig_pkg::CFG_ACTIVE:  active_r  <= cfg_data[mhsig_pkg::ACT_W-1:0];
        mhsig_pkg::CFG_MODULUS: modulus_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Hash reduction, four bits a cycle, most significant first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r <= '0;
    end else if (state_r == ST_IDLE) begin
      hcnt_r <= '0;
    end else if (state_r == ST_MOD) begin
      hcnt_r <= hcnt_r + mhsig_pkg::hcnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      hash_r <= in_element_hash;
      x_r    <= '0;
    end else if (state_r == ST_MOD) begin
      x_r    <= mhsig_pkg::rem_hash_digit(
                  x_r, hash_r[mhsig_pkg::HASH_W-1 -: mhsig_pkg::HASH_DIGIT], eff_mod);
      hash_r <= hash_r << mhsig_pkg::HASH_DIGIT;
    end
  end

  // Coefficient memory: written by load requests, read one slot a cycle during absorb.
  always_ff @(posedge clk) begin
    if (in_accept && (in_cmd == mhsig_pkg::CMD_LOAD) && (int'(in_slot) < MAX_HASHES)) begin
      coef_mem[SLOT_W'(in_slot)] <= {in_mult_coef, in_add_coef};
    end
    if (rd_en) begin
      coef_rd_r <= coef_mem[rd_addr];
    end
  end

  // Signature memory: read by absorb and emit, written back at the end of the pipeline.
  assign wb_addr = SLOT_W'(st_r[LAST_ST].slot);
  assign wb_en   = st_vld_r[LAST_ST] && (st_r[LAST_ST].rem < st_r[LAST_ST].old);

  always_ff @(posedge clk) begin
    if (wb_en) begin
      sig_mem[wb_addr] <= st_r[LAST_ST].rem;
    end
    if (rd_en) begin
      sig_rd_r  <= sig_mem[rd_addr];
      sigv_rd_r <= sig_vld_r[rd_addr];
      rd_slot_r <= idx_r;
    end
  end

  // A clear drops every valid bit and captures the modulus as the value of unwritten slots.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_vld_r   <= '0;
      clear_val_r <= mhsig_pkg::MODULUS_RST;
    end else if (in_accept && (in_cmd == mhsig_pkg::CMD_CLEAR)) begin
      sig_vld_r   <= '0;
      clear_val_r <= eff_mod;
    end else if (wb_en) begin
      sig_vld_r[wb_addr] <= 1'b1;
    end
  end

  // Update pipeline: multiply-add, then six remainder steps in each of four stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      st_vld_r <= '0;
    end else begin
      rd_vld_r <= (state_r == ST_ISSUE);
      st_vld_r <= {st_vld_r[LAST_ST-1:0], rd_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    st_r[0].rem  <= '0;
    st_r[0].bits <= mhsig_pkg::prod_t'(
                      mhsig_pkg::prod_t'(coef_rd_r[COEF_MW-1:mhsig_pkg::COEF_W]) *
                      mhsig_pkg::prod_t'(x_r))
                    + mhsig_pkg::prod_t'(coef_rd_r[mhsig_pkg::COEF_W-1:0]);
    st_r[0].old  <= slot_value;
    st_r[0].slot <= rd_slot_r;
    for (int k = 1; k <= LAST_ST; k++) begin
      st_r[k].rem  <= mhsig_pkg::rem_chunk(
                        st_r[k-1].rem,
                        st_r[k-1].bits[mhsig_pkg::PROD_W-1 -: mhsig_pkg::REM_STEPS],
                        eff_mod);
      st_r[k].bits <= st_r[k-1].bits << mhsig_pkg::REM_STEPS;
      st_r[k].old  <= st_r[k-1].old;
      st_r[k].slot <= st_r[k-1].slot;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= slot_value;
      out_slot_r  <= idx_r;
      out_last_r  <= idx_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sig_value = out_value_r;
  assign out_sig_slot  = out_slot_r;
  assign out_last      = out_last_r;

`ifndef NO_ASSERTIONS
  // Results appear only from the emit load step.
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_EMIT_LD))
    else $error("result raised outside the emit sequence");

  // The update pipeline holds slots only while an absorb is issuing or draining.
  a_pipe_in_absorb: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_busy |-> ((state_r == ST_ISSUE) || (state_r == ST_DRAIN)))
    else $error("update pipeline busy outside absorb");

  // The hash reduction runs its full number of digits before slots are issued.
  a_mod_length: assert property (@(posedge clk) disable iff (!rst_n)
    (($past(state_r) == ST_MOD) && (state_r == ST_ISSUE)) |->
    ($past(hcnt_r) == mhsig_pkg::HCNT_LAST))
    else $error("hash reduction ended early");

  // Write-back never targets a slot at or beyond LIMIT.
  a_wb_slot: assert property (@(posedge clk) disable iff (!rst_n)
    st_vld_r[LAST_ST] |-> (mhsig_pkg::cnt_t'(st_r[LAST_ST].slot) < LIMIT))
    else $error("write-back slot out of range");

  // A taken result clears the output register unless a new one is loaded.
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && (state_r != ST_EMIT_LD)) |=> !out_valid_r)
    else $error("result delivered twice");
`endif

endmodule
